// ===== sv/acl_pkg.sv =====
`timescale 1ns / 1ps
package acl_pkg;
    localparam int MaxRules = 256;
    localparam int IdxW = $clog2(MaxRules);
    localparam int CntW = IdxW + 1;
    localparam int QDepth = 2;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_CHECK = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic        rule_action;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] src_netmask;
        logic [31:0] dst_addr;
        logic [31:0] dst_netmask;
        logic [15:0] src_port_lo;
        logic [15:0] src_port_hi;
        logic [15:0] dst_port_lo;
        logic [15:0] dst_port_hi;
    } t_req;

    typedef struct packed {
        logic        status;
        logic        verdict;
        logic        matched;
        logic [7:0]  rule_index;
        logic [63:0] hits;
    } t_rsp;

    // rule as stored: addresses, masks, port ranges, protocol, action
    typedef struct packed {
        logic [31:0] sa;
        logic [31:0] sm;
        logic [31:0] da;
        logic [31:0] dm;
        logic [15:0] spl;
        logic [15:0] sph;
        logic [15:0] dpl;
        logic [15:0] dph;
        logic [7:0]  proto;
        logic        act;
    } t_rule;

    // compare a packet request with a stored rule
    function automatic logic rule_hit(t_rule r, t_req p);
        logic pr;
        logic ad;
        logic sp;
        logic dp;
        pr = (r.proto == 8'd0) || (r.proto == p.protocol);
        ad = ((p.src_addr & r.sm) == (r.sa & r.sm)) &&
             ((p.dst_addr & r.dm) == (r.da & r.dm));
        sp = ((r.spl == 16'd0) && (r.sph == 16'd0)) ||
             ((p.src_port_lo >= r.spl) && (p.src_port_lo <= r.sph));
        dp = ((r.dpl == 16'd0) && (r.dph == 16'd0)) ||
             ((p.dst_port_lo >= r.dpl) && (p.dst_port_lo <= r.dph));
        return pr && ad && sp && dp;
    endfunction
endpackage

// ===== sv/acl_ram.sv =====
`timescale 1ns / 1ps
module acl_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== sv/acl_fifo.sv =====
`timescale 1ns / 1ps
module acl_fifo
    import acl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_req o_data
);
    localparam int PtrW = $clog2(QDepth);
    t_req            r_q [QDepth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [PtrW:0]   r_cnt;
    logic            w_push, w_pop;

    assign w_push = i_push && !o_full;
    assign w_pop = i_pop && !o_empty;
    assign o_full = (r_cnt == (PtrW + 1)'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_data = r_q[r_rp];

    // hold requests between front and back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PtrW'(QDepth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PtrW'(QDepth - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PtrW + 1)'(w_push) - (PtrW + 1)'(w_pop);
        end
        if (w_push) begin
            r_q[r_wp] <= i_data;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PtrW + 1)'(QDepth)) else $error("queue overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty && !w_push |=> o_empty) else $error("queue grew without push");
    a_ptr_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> r_wp == r_rp) else $error("pointers differ when empty");
`endif
endmodule

// ===== sv/acl_engine.sv =====
`timescale 1ns / 1ps
module acl_engine
    import acl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_enable,
    input  logic i_empty,
    input  t_req i_req,
    output logic o_pop,
    output logic o_full,
    output t_rsp o_rsp,
    input  logic i_pop
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_CMP, S_HIT, S_OUT
    } t_state;

    localparam int RuleW = $bits(t_rule);

    t_state          r_state, n_state;
    logic [CntW-1:0] r_count, n_count;
    logic [IdxW-1:0] r_idx, n_idx;
    t_req            r_req, n_req;
    t_rsp            r_rsp, n_rsp;

    logic            w_rwe, w_hwe;
    logic [IdxW-1:0] w_waddr, w_hwaddr;
    t_rule           w_wrule, w_rule;
    logic [63:0]     w_hwdata, w_hits;

    acl_ram #(.Width(RuleW), .Depth(MaxRules)) u_rules (
        .i_clk(i_clk), .i_we(w_rwe), .i_waddr(w_waddr), .i_wdata(w_wrule),
        .i_raddr(r_idx), .o_rdata(w_rule)
    );
    acl_ram #(.Width(64), .Depth(MaxRules)) u_hits (
        .i_clk(i_clk), .i_we(w_hwe), .i_waddr(w_hwaddr), .i_wdata(w_hwdata),
        .i_raddr(r_idx), .o_rdata(w_hits)
    );

    assign o_full = (r_state == S_OUT);
    assign o_rsp = r_rsp;
    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        w_wrule = '{sa: i_req.src_addr, sm: i_req.src_netmask, da: i_req.dst_addr,
                    dm: i_req.dst_netmask, spl: i_req.src_port_lo,
                    sph: i_req.src_port_hi, dpl: i_req.dst_port_lo,
                    dph: i_req.dst_port_hi, proto: i_req.protocol,
                    act: i_req.rule_action};
        w_waddr = r_count[IdxW-1:0];
        w_rwe = o_pop && (i_req.func == FUNC_ADD) &&
                (r_count < CntW'(MaxRules));
        w_hwe = w_rwe || (r_state == S_HIT);
        w_hwaddr = (r_state == S_HIT) ? r_idx : w_waddr;
        w_hwdata = (r_state == S_HIT) ? w_hits + 64'd1 : 64'd0;
    end

    // sequence one request: decode, walk the rules on a check, publish
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx = r_idx;
        n_req = r_req;
        n_rsp = r_rsp;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_req = i_req;
                    n_rsp = '0;
                    n_idx = '0;
                    n_state = S_OUT;
                    priority if (i_req.func == FUNC_ADD) begin
                        if (r_count < CntW'(MaxRules)) begin
                            n_count = r_count + 1'b1;
                            n_rsp.rule_index = 8'(r_count);
                        end else begin
                            n_rsp.status = 1'b1;
                        end
                    end else if (i_req.func == FUNC_CHECK) begin
                        if (!i_enable) begin
                            n_rsp.verdict = 1'b0;
                        end else if (r_count == '0) begin
                            n_rsp.verdict = 1'b1;
                        end else begin
                            n_state = S_READ;
                        end
                    end else if (i_req.func == FUNC_CLEAR) begin
                        n_count = '0;
                    end else begin
                        n_rsp = '0;
                    end
                end
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (rule_hit(w_rule, r_req)) begin
                    n_rsp.verdict = w_rule.act;
                    n_rsp.matched = 1'b1;
                    n_rsp.rule_index = 8'(r_idx);
                    n_rsp.hits = w_hits + 64'd1;
                    n_state = S_HIT;
                end else if ((CntW'(r_idx) + 1'b1) == r_count) begin
                    n_rsp.verdict = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_READ;
                end
            end
            S_HIT: n_state = S_OUT;
            S_OUT: begin
                if (i_pop) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx <= n_idx;
        end
        r_req <= n_req;
        r_rsp <= n_rsp;
    end

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxRules)) else $error("rule count past table size");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && !i_pop |=> r_state == S_OUT && $stable(r_rsp))
        else $error("result changed while waiting");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |-> CntW'(r_idx) < r_count) else $error("walk past count");
`endif
endmodule

// ===== sv/ip_acl_first_match_classifier.sv =====
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// request   i_push / o_full        i_req (t_req)
// result    o_empty / i_pop        o_rsp (t_rsp)
// config    i_cfg_we               i_cfg_data (list_enable)
// A two-entry queue takes requests while the engine works on one at a time.
// Add, clear, bypassed checks skip the rule walk; the next starts once the result is popped.
// A check walks the rule RAM through the READ and CMP states per rule tried, plus HIT on a hit
// for the hit counter write; the READ state is set by the single registered RAM read port.
// Reset is synchronous; list_enable resets to 1, the rule table to empty.
// A held result stalls the engine; the queue then fills and raises o_full.
module ip_acl_first_match_classifier
    import acl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_req i_req,
    output logic o_empty,
    input  logic i_pop,
    output t_rsp o_rsp,
    input  logic i_cfg_we,
    input  logic i_cfg_data
);
    logic r_enable;
    logic w_qempty, w_qpop, w_busy;
    t_req w_qdata;

    // hold the list enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_data;
        end
    end

    acl_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_data(i_req),
        .o_full(o_full), .i_pop(w_qpop), .o_empty(w_qempty), .o_data(w_qdata)
    );

    acl_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_enable(r_enable),
        .i_empty(w_qempty), .i_req(w_qdata), .o_pop(w_qpop), .o_full(w_busy),
        .o_rsp(o_rsp), .i_pop(i_pop && !o_empty)
    );

    assign o_empty = !w_busy;
endmodule

// ===== test/acl_result_checker.sv =====
`timescale 1ns / 1ps
module acl_result_checker
    import acl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_full,
    input  t_req i_req,
    input  logic i_empty,
    input  logic i_pop,
    input  t_rsp i_rsp,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    output int   o_fail_count,
    output int   o_pending
);
    // shadow rule table and list enable
    t_rule       shadow_rules[MaxRules];
    logic [63:0] shadow_hits[MaxRules];
    int          shadow_count;
    logic        shadow_enable;
    t_rsp        expected_rsp_q[$];

    assign o_pending = expected_rsp_q.size();

    // classify one request against the shadow table
    function automatic t_rsp classify(t_req rq);
        t_rsp  rs;
        t_rule r;
        logic  pm;
        rs = '0;
        if (rq.func == FUNC_ADD) begin
            if (shadow_count >= MaxRules) begin
                rs.status = 1'b1;
            end else begin
                r.sa = rq.src_addr;     r.sm = rq.src_netmask;
                r.da = rq.dst_addr;     r.dm = rq.dst_netmask;
                r.spl = rq.src_port_lo; r.sph = rq.src_port_hi;
                r.dpl = rq.dst_port_lo; r.dph = rq.dst_port_hi;
                r.proto = rq.protocol;  r.act = rq.rule_action;
                shadow_rules[shadow_count] = r;
                shadow_hits[shadow_count] = '0;
                rs.rule_index = shadow_count[7:0];
                shadow_count++;
            end
        end else if (rq.func == FUNC_CHECK) begin
            if (!shadow_enable) return rs;
            for (int i = 0; i < shadow_count; i++) begin
                r = shadow_rules[i];
                pm = (r.proto == 8'd0 || r.proto == rq.protocol)
                    && ((rq.src_addr & r.sm) == (r.sa & r.sm))
                    && ((rq.dst_addr & r.dm) == (r.da & r.dm))
                    && ((r.spl == 0 && r.sph == 0)
                        || (rq.src_port_lo >= r.spl && rq.src_port_lo <= r.sph))
                    && ((r.dpl == 0 && r.dph == 0)
                        || (rq.dst_port_lo >= r.dpl && rq.dst_port_lo <= r.dph));
                if (pm) begin
                    shadow_hits[i] = shadow_hits[i] + 64'd1;
                    rs.verdict = r.act;
                    rs.matched = 1'b1;
                    rs.rule_index = i[7:0];
                    rs.hits = shadow_hits[i];
                    return rs;
                end
            end
            rs.verdict = 1'b1;
        end else if (rq.func == FUNC_CLEAR) begin
            shadow_count = 0;
        end
        return rs;
    endfunction

    // predict on accepted requests, compare on accepted results
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            shadow_count = 0;
            shadow_enable = 1'b1;
            o_fail_count = 0;
            expected_rsp_q.delete();
        end else begin
            if (i_cfg_we) shadow_enable = i_cfg_data;
            if (i_push && !i_full) expected_rsp_q.push_back(classify(i_req));
            if (i_pop && !i_empty) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fail_count++;
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (exp_rsp.status !== i_rsp.status) begin
                        $error("status exp %0h got %0h", exp_rsp.status, i_rsp.status);
                        o_fail_count++;
                    end
                    if (exp_rsp.verdict !== i_rsp.verdict) begin
                        $error("verdict exp %0h got %0h", exp_rsp.verdict, i_rsp.verdict);
                        o_fail_count++;
                    end
                    if (exp_rsp.matched !== i_rsp.matched) begin
                        $error("matched exp %0h got %0h", exp_rsp.matched, i_rsp.matched);
                        o_fail_count++;
                    end
                    if (exp_rsp.rule_index !== i_rsp.rule_index) begin
                        $error("rule_index exp %0h got %0h", exp_rsp.rule_index,
                               i_rsp.rule_index);
                        o_fail_count++;
                    end
                    if (exp_rsp.hits !== i_rsp.hits) begin
                        $error("hits exp %0h got %0h", exp_rsp.hits, i_rsp.hits);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== test/ip_acl_first_match_classifier_tb.sv =====
`timescale 1ns / 1ps
module ip_acl_first_match_classifier_tb
    import acl_pkg::*;
();
    localparam int CycleLimit = 3000000;
    localparam int ReqW = $bits(t_req);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_push = 1'b0;
    logic i_pop = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_data = 1'b1;
    t_req i_req = '0;
    logic o_full;
    logic o_empty;
    t_rsp o_rsp;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    bit   quiet_mode = 1'b0;
    t_rule pool[8];

    ip_acl_first_match_classifier dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_req(i_req), .o_empty(o_empty), .i_pop(i_pop), .o_rsp(o_rsp),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    acl_result_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_full(o_full),
        .i_req(i_req), .i_empty(o_empty), .i_pop(i_pop), .i_rsp(o_rsp),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // drain results with random stalls
    always @(negedge i_clk) begin
        i_pop <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 9);
    end

    // present one request and hold it until accepted; push stays high afterward
    task automatic send_request(t_req rq);
        bit idle;
        idle = !quiet_mode && ($urandom_range(99) < 9);
        if (idle) i_push <= 1'b0;
        while (idle) begin
            @(negedge i_clk);
            idle = !quiet_mode && ($urandom_range(99) < 9);
        end
        i_req <= rq;
        i_push <= 1'b1;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (1200) @(negedge i_clk);
    endtask

    task automatic write_enable(logic val);
        wait_drained();
        i_cfg_data <= val;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_req rule_request(t_rule r);
        t_req rq;
        rq.func = FUNC_ADD;  rq.rule_action = r.act;  rq.protocol = r.proto;
        rq.src_addr = r.sa;  rq.src_netmask = r.sm;
        rq.dst_addr = r.da;  rq.dst_netmask = r.dm;
        rq.src_port_lo = r.spl;  rq.src_port_hi = r.sph;
        rq.dst_port_lo = r.dpl;  rq.dst_port_hi = r.dph;
        return rq;
    endfunction

    function automatic t_rule random_rule();
        t_rule r;
        logic [15:0] a;
        logic [15:0] b;
        r.sa = $urandom();  r.da = $urandom();
        r.sm = ($urandom_range(3) == 0) ? $urandom() : ~32'h0 << $urandom_range(32, 8);
        r.dm = ($urandom_range(3) == 0) ? $urandom() : ~32'h0 << $urandom_range(32, 8);
        a = 16'($urandom());  b = 16'($urandom());
        case ($urandom_range(3))
            0: begin r.spl = 16'd0; r.sph = 16'd0; end
            1: begin r.spl = a; r.sph = b; end
            default: begin r.spl = (a < b) ? a : b; r.sph = (a < b) ? b : a; end
        endcase
        a = 16'($urandom());  b = 16'($urandom());
        case ($urandom_range(3))
            0: begin r.dpl = 16'd0; r.dph = 16'd0; end
            1: begin r.dpl = a; r.dph = b; end
            default: begin r.dpl = (a < b) ? a : b; r.dph = (a < b) ? b : a; end
        endcase
        r.proto = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(255));
        r.act = 1'($urandom());
        return r;
    endfunction

    // packet aimed near a pooled rule, or pure noise
    function automatic t_req packet_request();
        t_req  rq;
        t_rule r;
        rq = t_req'(ReqW'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom()}));
        rq.func = FUNC_CHECK;
        if ($urandom_range(4) != 0) begin
            r = pool[$urandom_range(7)];
            rq.src_addr = (r.sa & r.sm) | (rq.src_addr & ~r.sm);
            rq.dst_addr = (r.da & r.dm) | (rq.dst_addr & ~r.dm);
            if (r.proto != 0) rq.protocol = r.proto;
            if (r.spl <= r.sph) rq.src_port_lo = 16'($urandom_range(r.sph, r.spl));
            if (r.dpl <= r.dph) rq.dst_port_lo = 16'($urandom_range(r.dph, r.dpl));
        end
        return rq;
    endfunction

    initial begin
        t_req  rq;
        t_rule r;
        int    pick;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: any-rules, inverted ranges, extremes, clear, unused code
        r = '0;
        r.act = 1'b1;
        r.proto = 8'd255;
        r.sm = 32'hFFFF_FFFF;  r.sa = 32'hFFFF_FFFF;
        r.spl = 16'hFFFF;  r.sph = 16'hFFFF;
        send_request(rule_request(r));
        r = '0;
        r.spl = 16'd10;  r.sph = 16'd5;
        send_request(rule_request(r));
        r = '0;
        r.act = 1'b0;
        send_request(rule_request(r));
        rq = '0;
        rq.func = FUNC_CHECK;
        send_request(rq);
        rq = '1;
        rq.func = FUNC_CHECK;
        send_request(rq);
        rq.src_port_lo = 16'd7;
        send_request(rq);
        rq = '1;
        send_request(rq);
        rq = '0;
        rq.func = FUNC_CLEAR;
        send_request(rq);
        rq.func = FUNC_CHECK;
        send_request(rq);

        // fill the table, overflow it, then disable the list
        for (int i = 0; i < 8; i++) pool[i] = random_rule();
        for (int i = 0; i < MaxRules + 2; i++) send_request(rule_request(pool[i % 8]));
        rq = '0;
        rq.func = FUNC_CHECK;
        send_request(rq);
        write_enable(1'b0);
        send_request(packet_request());
        send_request(rq);
        write_enable(1'b1);

        // random traffic, mostly small rule tables
        for (int n = 0; n < 780; n++) begin
            if (n == 300) quiet_mode = 1'b1;
            if (n == 450) quiet_mode = 1'b0;
            if (n == 550) wait_drained();
            if (n == 620 || n == 700) write_enable(n == 700);
            pick = $urandom_range(99);
            if (pick < 3) begin
                rq = '0;
                rq.func = FUNC_CLEAR;
                for (int i = 0; i < 8; i++) pool[i] = random_rule();
            end else if (pick < 25) begin
                rq = rule_request(pool[$urandom_range(7)]);
            end else if (pick < 27) begin
                rq = t_req'(ReqW'({$urandom(), $urandom(), $urandom(), $urandom(),
                                   $urandom(), $urandom(), $urandom(), $urandom()}));
            end else begin
                rq = packet_request();
            end
            send_request(rq);
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== ip_acl_first_match_classifier.f =====
sv/acl_pkg.sv
sv/acl_ram.sv
sv/acl_fifo.sv
sv/acl_engine.sv
sv/ip_acl_first_match_classifier.sv
test/acl_result_checker.sv
test/ip_acl_first_match_classifier_tb.sv
